[hdl/trm_pkg.sv]
// Shared types, constants and the microcode program of the register machine execute block.
// Used by every other file of the block but trm_ram; it depends on nothing.
package trm_pkg;

  // Machine geometry.
  localparam int NumRegs  = 16;
  localparam int RegIdxW  = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam int IdxW     = 4;
  localparam int DataW    = 16;
  localparam int SumW     = DataW + 1;
  localparam int FuncW    = 3;
  localparam int UpcW     = 4;
  localparam int CntW     = 4;
  localparam int DivSteps = DataW;

  typedef logic [RegIdxW-1:0] ridx_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [DataW-1:0]   data_t;
  typedef logic [SumW-1:0]    sum_t;
  typedef logic [FuncW-1:0]   func_t;
  typedef logic [UpcW-1:0]    upc_t;
  typedef logic [CntW-1:0]    cnt_t;

  // Opcodes.
  localparam func_t OpAdd  = 3'd0;
  localparam func_t OpSub  = 3'd1;
  localparam func_t OpMul  = 3'd2;
  localparam func_t OpDiv  = 3'd3;
  localparam func_t OpBgt  = 3'd4;
  localparam func_t OpBle  = 3'd5;
  localparam func_t OpHalt = 3'd6;

  // Sequencer conditions.
  localparam logic [2:0] CondNext     = 3'd0;
  localparam logic [2:0] CondJump     = 3'd1;
  localparam logic [2:0] CondWaitIn   = 3'd2;
  localparam logic [2:0] CondWaitOut  = 3'd3;
  localparam logic [2:0] CondDispatch = 3'd4;
  localparam logic [2:0] CondLoop     = 3'd5;

  // Result kinds issued to the output register.
  localparam logic [1:0] EmitNone   = 2'd0;
  localparam logic [1:0] EmitWrite  = 2'd1;
  localparam logic [1:0] EmitBranch = 2'd2;
  localparam logic [1:0] EmitHalt   = 2'd3;

  // Program steps.
  localparam upc_t StepFetch   = 4'd0;
  localparam upc_t StepRdSrc   = 4'd1;
  localparam upc_t StepRdDst   = 4'd2;
  localparam upc_t StepOpnd    = 4'd3;
  localparam upc_t StepArith   = 4'd4;
  localparam upc_t StepDivInit = 4'd5;
  localparam upc_t StepDivStep = 4'd6;
  localparam upc_t StepWrite   = 4'd7;
  localparam upc_t StepBranch  = 4'd8;
  localparam upc_t StepHalt    = 4'd9;

  // One control word of the program.
  typedef struct packed {
    logic [2:0] cond;
    upc_t       target;
    logic       rd_dst;
    logic       ld_src;
    logic       ld_dst;
    logic       alu_ld;
    logic       div_init;
    logic       div_step;
    logic [1:0] emit;
  } ctrl_t;

  // Control from the sequencer: the current word and whether its condition is met.
  typedef struct packed {
    ctrl_t word;
    logic  fire;
  } uctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic  in_valid;
    logic  out_free;
    func_t func;
  } stat_t;

  // Register index reduction table, built at elaboration.
  function automatic logic [15:0][IdxW-1:0] build_sel();
    logic [15:0][IdxW-1:0] t;
    for (int i = 0; i < 16; i++) begin
      t[i] = IdxW'(i % NumRegs);
    end
    return t;
  endfunction

  localparam logic [15:0][IdxW-1:0] RegSelTable = build_sel();

  function automatic ctrl_t mk(logic [2:0] cond, upc_t target, logic rd_dst, logic ld_src,
                               logic ld_dst, logic alu_ld, logic div_init, logic div_step,
                               logic [1:0] emit);
    ctrl_t w;
    w.cond     = cond;
    w.target   = target;
    w.rd_dst   = rd_dst;
    w.ld_src   = ld_src;
    w.ld_dst   = ld_dst;
    w.alu_ld   = alu_ld;
    w.div_init = div_init;
    w.div_step = div_step;
    w.emit     = emit;
    return w;
  endfunction

  // The program ROM.
  function automatic ctrl_t ucode(upc_t upc);
    ctrl_t w;
    unique case (upc)
      StepFetch:   w = mk(CondWaitIn,   StepRdSrc, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EmitNone);
      StepRdSrc:   w = mk(CondNext,     StepFetch, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EmitNone);
      StepRdDst:   w = mk(CondNext,     StepFetch, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EmitNone);
      StepOpnd:    w = mk(CondDispatch, StepFetch, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, EmitNone);
      StepArith:   w = mk(CondJump,     StepWrite, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, EmitNone);
      StepDivInit: w = mk(CondNext,     StepFetch, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EmitNone);
      StepDivStep: w = mk(CondLoop,     StepWrite, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, EmitNone);
      StepWrite:   w = mk(CondWaitOut,  StepFetch, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EmitWrite);
      StepBranch:  w = mk(CondWaitOut,  StepFetch, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EmitBranch);
      StepHalt:    w = mk(CondWaitOut,  StepFetch, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EmitHalt);
      default:     w = mk(CondJump,     StepFetch, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EmitNone);
    endcase
    return w;
  endfunction

  // Dispatch table: first step of each opcode's routine.
  function automatic upc_t dispatch(func_t func);
    upc_t t;
    unique case (func)
      OpAdd, OpSub, OpMul: t = StepArith;
      OpDiv:               t = StepDivInit;
      OpBgt, OpBle:        t = StepBranch;
      default:             t = StepHalt;
    endcase
    return t;
  endfunction

endpackage

[hdl/trm_in_if.sv]
// Instruction channel of the register machine execute block: valid, ready and one instruction.
// Depends on trm_pkg.
interface trm_in_if;
  logic                 valid;
  logic                 ready;
  trm_pkg::func_t       func;
  trm_pkg::idx_t        dest_index;
  trm_pkg::idx_t        src_index;
  trm_pkg::data_t       immediate;

  modport source (output valid, func, dest_index, src_index, immediate, input ready);
  modport sink   (input valid, func, dest_index, src_index, immediate, output ready);
endinterface

[hdl/trm_out_if.sv]
// Result channel of the register machine execute block: valid, ready and one result word.
// Depends on trm_pkg.
interface trm_out_if;
  logic           valid;
  logic           ready;
  trm_pkg::data_t next_pointer;
  logic           reg_written;
  trm_pkg::idx_t  write_index;
  trm_pkg::data_t write_value;
  logic           halted;
  logic           div_zero;

  modport source (output valid, next_pointer, reg_written, write_index, write_value, halted,
                  div_zero, input ready);
  modport sink   (input valid, next_pointer, reg_written, write_index, write_value, halted,
                  div_zero, output ready);
endinterface

[hdl/trm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; depends on nothing.
module trm_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                         wdata,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                         rdata
);

  logic [Width-1:0] mem_r [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[hdl/trm_useq.sv]
// Microcode sequencer: step counter, program ROM, loop counter and conditional jumps.
// Depends on trm_pkg.
module trm_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  trm_pkg::stat_t stat,
  output trm_pkg::uctl_t ctl
);

  trm_pkg::upc_t  upc_r, upc_nxt;
  trm_pkg::cnt_t  cnt_r, cnt_nxt;
  trm_pkg::ctrl_t word;
  logic           fire;

  assign word = trm_pkg::ucode(upc_r);

  // A step that waits on a channel fires only when that channel can move.
  always_comb begin
    unique case (word.cond)
      trm_pkg::CondWaitIn:  fire = stat.in_valid;
      trm_pkg::CondWaitOut: fire = stat.out_free;
      default:              fire = 1'b1;
    endcase
  end

  assign ctl.word = word;
  assign ctl.fire = fire;

  // Next step and loop count.
  always_comb begin
    upc_nxt = upc_r;
    cnt_nxt = cnt_r;
    if (word.div_init) begin
      cnt_nxt = trm_pkg::cnt_t'(trm_pkg::DivSteps - 1);
    end
    unique case (word.cond)
      trm_pkg::CondNext:     upc_nxt = upc_r + 1'b1;
      trm_pkg::CondJump:     upc_nxt = word.target;
      trm_pkg::CondDispatch: upc_nxt = trm_pkg::dispatch(stat.func);
      trm_pkg::CondWaitIn, trm_pkg::CondWaitOut: begin
        if (fire) begin
          upc_nxt = word.target;
        end
      end
      trm_pkg::CondLoop: begin
        if (cnt_r == '0) begin
          upc_nxt = word.target;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: upc_nxt = trm_pkg::StepFetch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= trm_pkg::StepFetch;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  // The divide loop keeps iterating until its count runs out.
  assert property (@(posedge clk) disable iff (!rst_n)
    (word.cond == trm_pkg::CondLoop && cnt_r != '0) |=> upc_r == trm_pkg::StepDivStep)
    else $error("divide loop left early");
`endif

endmodule

[hdl/trm_datapath.sv]
// Datapath: operand registers, register file RAM with valid bits, ALU, restoring divider,
// instruction pointer and the output register. Depends on trm_pkg, trm_ram and the channels.
module trm_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  trm_pkg::uctl_t ctl,
  output trm_pkg::stat_t stat,
  trm_in_if.sink         in_ch,
  trm_out_if.source      out_ch
);

  logic                         in_fire;
  logic                         out_free;
  logic                         emit_fire;
  trm_pkg::func_t               func_r;
  trm_pkg::idx_t                di_r;
  trm_pkg::idx_t                si_r;
  trm_pkg::data_t               imm_r;
  trm_pkg::data_t               src_r;
  trm_pkg::data_t               dst_r;
  trm_pkg::sum_t                sum_r;
  trm_pkg::data_t               res_r;
  trm_pkg::sum_t                rem_r;
  trm_pkg::data_t               ip_r;
  logic [trm_pkg::NumRegs-1:0]  vld_r;
  logic                         rvld_r;
  trm_pkg::ridx_t               raddr;
  trm_pkg::ridx_t               waddr;
  trm_pkg::data_t               rdata;
  trm_pkg::data_t               operand;
  trm_pkg::data_t               alu;
  logic [2*trm_pkg::DataW-1:0]  prod;
  logic [trm_pkg::SumW:0]       shifted;
  logic [trm_pkg::SumW:0]       trial;
  trm_pkg::data_t               ip_step;
  logic                         taken;
  logic                         out_valid_r;
  trm_pkg::data_t               out_ptr_r;
  logic                         out_wr_r;
  trm_pkg::idx_t                out_idx_r;
  trm_pkg::data_t               out_val_r;
  logic                         out_halt_r;
  logic                         out_dz_r;

  assign in_ch.ready = (ctl.word.cond == trm_pkg::CondWaitIn);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit_fire   = ctl.fire && (ctl.word.emit != trm_pkg::EmitNone);

  assign stat.in_valid = in_ch.valid;
  assign stat.out_free = out_free;
  assign stat.func     = func_r;

  // Latch the instruction word; indices are reduced to the register count here.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_ch.func;
      di_r   <= trm_pkg::RegSelTable[in_ch.dest_index];
      si_r   <= trm_pkg::RegSelTable[in_ch.src_index];
      imm_r  <= in_ch.immediate;
    end
  end

  // Register file: the RAM holds the data, valid bits stand in for the cleared reset state.
  assign raddr = ctl.word.rd_dst ? trm_pkg::ridx_t'(di_r) : trm_pkg::ridx_t'(si_r);
  assign waddr = trm_pkg::ridx_t'(di_r);

  trm_ram #(
    .Width (trm_pkg::DataW),
    .Depth (trm_pkg::NumRegs)
  ) u_regs (
    .clk   (clk),
    .we    (emit_fire && ctl.word.emit == trm_pkg::EmitWrite),
    .waddr (waddr),
    .wdata (res_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (emit_fire && ctl.word.emit == trm_pkg::EmitWrite) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign operand = rvld_r ? rdata : '0;

  // Arithmetic on the low half of the sum; its carry bit drops out modulo 2^16.
  assign prod = dst_r * sum_r[trm_pkg::DataW-1:0];

  always_comb begin
    unique case (func_r)
      trm_pkg::OpAdd: alu = dst_r + sum_r[trm_pkg::DataW-1:0];
      trm_pkg::OpSub: alu = dst_r - sum_r[trm_pkg::DataW-1:0];
      default:        alu = prod[trm_pkg::DataW-1:0];
    endcase
  end

  // One restoring divide step per cycle; a zero divisor yields all ones on its own.
  assign shifted = {rem_r, res_r[trm_pkg::DataW-1]};
  assign trial   = shifted - {1'b0, sum_r};

  always_ff @(posedge clk) begin
    if (ctl.word.ld_src) begin
      src_r <= operand;
      sum_r <= trm_pkg::sum_t'(operand) + trm_pkg::sum_t'(imm_r);
    end
    if (ctl.word.ld_dst) begin
      dst_r <= operand;
    end
    if (ctl.word.alu_ld) begin
      res_r <= alu;
    end else if (ctl.word.div_init) begin
      res_r <= dst_r;
      rem_r <= '0;
    end else if (ctl.word.div_step) begin
      if (!trial[trm_pkg::SumW]) begin
        rem_r <= trial[trm_pkg::SumW-1:0];
        res_r <= {res_r[trm_pkg::DataW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[trm_pkg::SumW-1:0];
        res_r <= {res_r[trm_pkg::DataW-2:0], 1'b0};
      end
    end
  end

  // Branch decision and pointer update.
  assign ip_step = ip_r + 1'b1;
  assign taken   = (func_r == trm_pkg::OpBgt) ? (dst_r > src_r) : (dst_r <= src_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r <= '0;
    end else if (emit_fire) begin
      unique case (ctl.word.emit)
        trm_pkg::EmitWrite:  ip_r <= ip_step;
        trm_pkg::EmitBranch: ip_r <= taken ? imm_r : ip_step;
        default:             ip_r <= ip_r;
      endcase
    end
  end

  // Output register: loads a result word, clears once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Each result kind sets every field of the word exactly once.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      unique case (ctl.word.emit)
        trm_pkg::EmitWrite: begin
          out_ptr_r  <= ip_step;
          out_wr_r   <= 1'b1;
          out_idx_r  <= di_r;
          out_val_r  <= res_r;
          out_halt_r <= 1'b0;
          out_dz_r   <= (func_r == trm_pkg::OpDiv) && (sum_r == '0);
        end
        trm_pkg::EmitBranch: begin
          out_ptr_r  <= taken ? imm_r : ip_step;
          out_wr_r   <= 1'b0;
          out_idx_r  <= '0;
          out_val_r  <= '0;
          out_halt_r <= 1'b0;
          out_dz_r   <= 1'b0;
        end
        default: begin
          out_ptr_r  <= ip_r;
          out_wr_r   <= 1'b0;
          out_idx_r  <= '0;
          out_val_r  <= '0;
          out_halt_r <= 1'b1;
          out_dz_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.next_pointer = out_ptr_r;
  assign out_ch.reg_written  = out_wr_r;
  assign out_ch.write_index  = out_idx_r;
  assign out_ch.write_value  = out_val_r;
  assign out_ch.halted       = out_halt_r;
  assign out_ch.div_zero     = out_dz_r;

`ifndef SYNTH
  // Only one instruction is in flight: taking one closes the input until it is done.
  assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ch.ready)
    else $error("second instruction accepted while one is executing");

  // A divide-by-zero flag only ever comes with a register write.
  assert property (@(posedge clk) disable iff (!rst_n) (out_valid_r && out_dz_r) |-> out_wr_r)
    else $error("divide-by-zero flag without a write");

  // A halt never writes the register file.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_halt_r) |-> (!out_wr_r && out_ptr_r == ip_r))
    else $error("halt result changed state");
`endif

endmodule

[hdl/tiny_register_machine_execute.sv]
// Usage:
// Executes one instruction of a small 16-bit register machine per word on in_ch and
// returns one result word on out_ch. Both channels use valid/ready; a word moves at a
// rising edge where both are high. The block holds sixteen 16-bit registers and a 16-bit
// instruction pointer, both zero after a synchronous reset (rst_n low), which also empties
// the output register. The register file sits in a RAM; per-entry valid bits make entries
// not yet written read as zero, so no clearing pass follows reset.
// A microcoded sequencer steps a small datapath through each instruction, one instruction
// at a time. After an instruction is accepted, the sequencer reads its source and then its
// destination register, runs the ALU step for add, sub and mul or the one-bit-per-cycle
// restoring divide loop for div (neither for branches and halt) and loads the result into the
// output register; the next instruction can be accepted in the following cycle.
// The output register lets the block take and run the next instruction while a result
// waits; if that result is still not taken when the next one is ready, the sequencer holds
// at its final step until out_ch.ready frees the register.
// Depends on trm_pkg, trm_in_if, trm_out_if, trm_useq, trm_datapath and trm_ram.
module tiny_register_machine_execute (
  input  logic      clk,
  input  logic      rst_n,
  trm_in_if.sink    in_ch,
  trm_out_if.source out_ch
);

  trm_pkg::uctl_t ctl;
  trm_pkg::stat_t stat;

  // Program sequencer.
  trm_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Datapath and channels.
  trm_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
